>>> rtl/carrt_pkg.sv
// ----------------------------------------------------------------------------
// carrt_pkg: shared types and constants for the arc run tracker
// Direction codes, field widths and packing offsets of the stream channels.
// ----------------------------------------------------------------------------
package carrt_pkg;

   // Fixed field widths of the stream items
   localparam int FIELD_X_BITS    = 12;
   localparam int FIELD_SIZE_BITS = 10;
   localparam int PTS_BITS        = 10;
   localparam int PTS_LIMIT       = 1023;

   // Request tdata: pos_x, pos_y, contour_size (34 bits, padded to 40)
   localparam int REQ_DATA_BITS   = 40;
   localparam int REQ_X_LSB       = 0;
   localparam int REQ_Y_LSB       = 12;
   localparam int REQ_SIZE_LSB    = 24;
   // Request tuser: contour_start, search_start
   localparam int REQ_USER_BITS   = 2;
   localparam int REQ_USER_CSTART = 0;
   localparam int REQ_USER_SSTART = 1;

   // Response tdata: min x, max x, width, points (46 bits, padded to 48)
   localparam int RSP_DATA_BITS   = 48;
   localparam int RSP_PAD_BITS    = 2;

   // Contours shorter than this are skipped
   localparam logic [FIELD_SIZE_BITS-1:0] MIN_CONTOUR = 10'd3;

   // Saturation point and break threshold of the y reversal counter
   localparam logic [1:0] UPC_MAX   = 2'd3;
   localparam logic [1:0] UPC_LIMIT = 2'd1;

   typedef enum logic [1:0] {
      XD_LEFT  = 2'd0,
      XD_RIGHT = 2'd1,
      XD_NONE  = 2'd2,
      XD_INIT  = 2'd3
   } xdir_type;

   // UP means y falling, DOWN means y rising (image coordinates)
   typedef enum logic [1:0] {
      YD_UP   = 2'd0,
      YD_DOWN = 2'd1,
      YD_NONE = 2'd2
   } ydir_type;

endpackage

>>> rtl/contour_arc_run_tracker.sv
// ----------------------------------------------------------------------------
// contour_arc_run_tracker: longest monotone arc search over contour vertices
// Tracks x-monotone runs with one y turn and reports the best run per search.
// ----------------------------------------------------------------------------
// The block takes one contour vertex per item and sustains one item per clock
// unless the input stalls. Each item is held in an input register, then the
// run and best-run state is updated by a single pass of compare/select logic,
// and an item that carries req_tlast (end of search) loads the result register
// as it leaves the input register; the result is offered from then on until
// it is taken. Items without req_tlast make no result and always flow; the
// input stalls only when an end-of-search item sits in the input register
// while the previous result is still not taken.
// A run breaks on a flat step (dropped, restarts at this vertex), on an x
// reversal or a y turn other than one rise-to-fall turn (scored against the
// best run, restarts at the previous vertex). The last run of a contour is
// never scored. Contours whose size is below three are ignored; req_tuser[1]
// clears the best run first.
// ----------------------------------------------------------------------------
module contour_arc_run_tracker #(
   parameter int COORD_BITS   = 12,
   parameter int MAX_VERTICES = 1023
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [11:0] pos_x, [23:12] pos_y, [33:24] contour_size, [39:34] zero
   input  logic [carrt_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [0] contour_start, [1] search_start
   input  logic [carrt_pkg::REQ_USER_BITS-1:0] req_tuser,
   // search_end
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [11:0] best_min_x, [23:12] best_max_x, [35:24] best_width,
   // [45:36] best_points, [47:46] zero
   output logic [carrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] found
   output logic                                rsp_tuser
);

   localparam int FX = carrt_pkg::FIELD_X_BITS;
   localparam int PB = carrt_pkg::PTS_BITS;
   localparam int PtsCap = (MAX_VERTICES < carrt_pkg::PTS_LIMIT) ?
                           MAX_VERTICES : carrt_pkg::PTS_LIMIT;
   localparam logic [PB-1:0] PTS_CAP = PB'(PtsCap);
   localparam logic [PB-1:0] PTS_ONE = PB'(1);
   localparam logic [PB-1:0] PTS_TWO = PB'(2);

   // ---------------- input register ----------------
   logic                                    in_valid_ff, in_valid_in;
   logic [COORD_BITS-1:0]                   in_x_ff, in_y_ff;
   logic [carrt_pkg::FIELD_SIZE_BITS-1:0]   in_size_ff;
   logic                                    in_cstart_ff, in_sstart_ff, in_send_ff;
   logic                                    load_in, advance;

   // ---------------- run state ----------------
   carrt_pkg::xdir_type   xd_ff, xd_in;
   carrt_pkg::ydir_type   yd_ff, yd_in;
   logic [COORD_BITS-1:0] run_min_ff, run_min_in, run_max_ff, run_max_in;
   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [1:0]            upc_ff, upc_in;
   logic [PB-1:0]         pts_ff, pts_in;

   // ---------------- best run ----------------
   logic [PB-1:0]         top_pts_ff, top_pts_in;
   logic [COORD_BITS-1:0] top_min_ff, top_min_in, top_max_ff, top_max_in;
   logic [COORD_BITS-1:0] top_w_ff, top_w_in;

   // ---------------- result register ----------------
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [carrt_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_found_ff, rsp_found_in;

   // An end-of-search item needs a free result slot; others always move on.
   assign advance    = in_valid_ff && (!in_send_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign load_in    = req_tvalid && req_tready;
   assign in_valid_in = load_in || (in_valid_ff && !advance);

   // ---------------- vertex evaluation ----------------
   logic                  take;
   carrt_pkg::xdir_type   xd_r;
   carrt_pkg::ydir_type   yd_r;
   logic [COORD_BITS-1:0] min_r, max_r, px_r, py_r;
   logic [1:0]            upc_r, upc_inc;
   logic [PB-1:0]         pts_r, pts_inc;
   logic [PB-1:0]         tp0;
   logic [COORD_BITS-1:0] tmin0, tmax0, tw0, run_w;
   logic                  x_up, y_up, x_fail, y_fail, flat;
   carrt_pkg::xdir_type   xd_step;
   carrt_pkg::ydir_type   yd_step;
   logic [1:0]            upc_step;
   logic                  better;

   always_comb begin
      // search start clears the best run before the vertex is taken
      tp0   = in_sstart_ff ? '0 : top_pts_ff;
      tmin0 = in_sstart_ff ? '0 : top_min_ff;
      tmax0 = in_sstart_ff ? '0 : top_max_ff;
      tw0   = in_sstart_ff ? '0 : top_w_ff;

      take = (in_size_ff >= carrt_pkg::MIN_CONTOUR);

      // new contour reopens the run
      if (in_cstart_ff) begin
         xd_r  = carrt_pkg::XD_INIT;
         yd_r  = carrt_pkg::YD_NONE;
         min_r = '0;
         max_r = '0;
         px_r  = '0;
         py_r  = '0;
         upc_r = '0;
         pts_r = '0;
      end else begin
         xd_r  = xd_ff;
         yd_r  = yd_ff;
         min_r = run_min_ff;
         max_r = run_max_ff;
         px_r  = prev_x_ff;
         py_r  = prev_y_ff;
         upc_r = upc_ff;
         pts_r = pts_ff;
      end

      pts_inc = (pts_r < PTS_CAP) ? pts_r + PTS_ONE : pts_r;
      flat    = (in_x_ff == px_r) || (in_y_ff == py_r);
      run_w   = max_r - min_r;

      // x step
      x_up    = in_x_ff > px_r;
      x_fail  = x_up ? (xd_r == carrt_pkg::XD_LEFT) : (xd_r == carrt_pkg::XD_RIGHT);
      xd_step = x_up ? carrt_pkg::XD_RIGHT : carrt_pkg::XD_LEFT;

      // y step; a turn from rising to falling counts toward the one allowed
      y_up     = in_y_ff > py_r;
      upc_inc  = (upc_r < carrt_pkg::UPC_MAX) ? upc_r + 2'd1 : upc_r;
      if (y_up) begin
         y_fail   = (yd_r == carrt_pkg::YD_UP);
         yd_step  = carrt_pkg::YD_DOWN;
         upc_step = upc_r;
      end else if (yd_r == carrt_pkg::YD_DOWN) begin
         y_fail   = (upc_inc > carrt_pkg::UPC_LIMIT);
         yd_step  = carrt_pkg::YD_UP;
         upc_step = upc_inc;
      end else begin
         y_fail   = 1'b0;
         yd_step  = carrt_pkg::YD_UP;
         upc_step = upc_r;
      end

      // scored count includes the breaking vertex
      better = (pts_inc > tp0) || ((pts_inc == tp0) && (run_w > tw0));

      xd_in      = xd_r;
      yd_in      = yd_r;
      run_min_in = min_r;
      run_max_in = max_r;
      prev_x_in  = px_r;
      prev_y_in  = py_r;
      upc_in     = upc_r;
      pts_in     = pts_r;
      top_pts_in = tp0;
      top_min_in = tmin0;
      top_max_in = tmax0;
      top_w_in   = tw0;

      if (!take) begin
         // short contour: the run state does not change, not even on a contour start
         xd_in      = xd_ff;
         yd_in      = yd_ff;
         run_min_in = run_min_ff;
         run_max_in = run_max_ff;
         prev_x_in  = prev_x_ff;
         prev_y_in  = prev_y_ff;
         upc_in     = upc_ff;
         pts_in     = pts_ff;
      end else if (xd_r == carrt_pkg::XD_INIT) begin
         xd_in      = carrt_pkg::XD_NONE;
         run_min_in = in_x_ff;
         run_max_in = in_x_ff;
         prev_x_in  = in_x_ff;
         prev_y_in  = in_y_ff;
         pts_in     = pts_inc;
      end else if (flat) begin
         // flat step: drop the run unscored
         xd_in      = carrt_pkg::XD_NONE;
         yd_in      = carrt_pkg::YD_NONE;
         upc_in     = '0;
         pts_in     = PTS_ONE;
         run_min_in = in_x_ff;
         run_max_in = in_x_ff;
         prev_x_in  = in_x_ff;
         prev_y_in  = in_y_ff;
      end else if (!x_fail && !y_fail) begin
         xd_in     = xd_step;
         yd_in     = yd_step;
         upc_in    = upc_step;
         pts_in    = pts_inc;
         prev_x_in = in_x_ff;
         prev_y_in = in_y_ff;
         if (in_x_ff < min_r) begin
            run_min_in = in_x_ff;
         end else if (in_x_ff > max_r) begin
            run_max_in = in_x_ff;
         end
      end else begin
         // break: score, restart at the previous vertex, then take this one
         if (better) begin
            top_pts_in = pts_inc;
            top_min_in = min_r;
            top_max_in = max_r;
            top_w_in   = run_w;
         end
         xd_in     = xd_step;
         yd_in     = yd_step;
         upc_in    = '0;
         pts_in    = PTS_TWO;
         prev_x_in = in_x_ff;
         prev_y_in = in_y_ff;
         if (x_up) begin
            run_min_in = px_r;
            run_max_in = in_x_ff;
         end else begin
            run_min_in = in_x_ff;
            run_max_in = px_r;
         end
      end
   end

   // ---------------- result ----------------
   always_comb begin
      rsp_data_in  = {{carrt_pkg::RSP_PAD_BITS{1'b0}}, top_pts_in, FX'(top_w_in),
                      FX'(top_max_in), FX'(top_min_in)};
      rsp_found_in = (top_w_in != '0);
      if (advance && in_send_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         xd_ff        <= carrt_pkg::XD_INIT;
         yd_ff        <= carrt_pkg::YD_NONE;
         run_min_ff   <= '0;
         run_max_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         upc_ff       <= '0;
         pts_ff       <= '0;
         top_pts_ff   <= '0;
         top_min_ff   <= '0;
         top_max_ff   <= '0;
         top_w_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            xd_ff      <= xd_in;
            yd_ff      <= yd_in;
            run_min_ff <= run_min_in;
            run_max_ff <= run_max_in;
            prev_x_ff  <= prev_x_in;
            prev_y_ff  <= prev_y_in;
            upc_ff     <= upc_in;
            pts_ff     <= pts_in;
            top_pts_ff <= top_pts_in;
            top_min_ff <= top_min_in;
            top_max_ff <= top_max_in;
            top_w_ff   <= top_w_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_x_ff      <= COORD_BITS'(req_tdata[carrt_pkg::REQ_X_LSB +: FX]);
         in_y_ff      <= COORD_BITS'(req_tdata[carrt_pkg::REQ_Y_LSB +: FX]);
         in_size_ff   <= req_tdata[carrt_pkg::REQ_SIZE_LSB +: carrt_pkg::FIELD_SIZE_BITS];
         in_cstart_ff <= req_tuser[carrt_pkg::REQ_USER_CSTART];
         in_sstart_ff <= req_tuser[carrt_pkg::REQ_USER_SSTART];
         in_send_ff   <= req_tlast;
      end
      if (advance && in_send_ff) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_found_ff <= rsp_found_in;
      end
   end

`ifndef ASSERT_OFF
   // point count stays within its saturation limit
   a_pts_cap: assert property (@(posedge clock) disable iff (reset)
      pts_ff <= PTS_CAP)
      else $error("run point count above cap");

   // a second y turn always breaks the run, so at most one is ever kept
   a_upc: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= carrt_pkg::UPC_LIMIT)
      else $error("y turn counter kept above one");

   // an empty run is exactly a run awaiting its first vertex
   a_open: assert property (@(posedge clock) disable iff (reset)
      (pts_ff == '0) == (xd_ff == carrt_pkg::XD_INIT))
      else $error("run count and x direction disagree");

   // best width always matches its extent
   a_top_w: assert property (@(posedge clock) disable iff (reset)
      top_w_ff == top_max_ff - top_min_ff)
      else $error("best width inconsistent");

   // an end-of-search item that moves on yields a result next cycle
   a_emit: assert property (@(posedge clock) disable iff (reset)
      advance && in_send_ff |=> rsp_tvalid)
      else $error("search end item produced no result");
`endif

endmodule

>>> bench/contour_arc_run_tracker_test.sv
// ----------------------------------------------------------------------------
// contour_arc_run_tracker_test: self-checking bench for the arc run tracker
// Streams contour vertices through the block and checks every best-run item
// against a run-tracking predictor. The sender idles in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module contour_arc_run_tracker_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;   // long receiver hold-off

   // One vertex item as the bench sees it
   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
      logic        cstart;
      logic [9:0]  size;
      logic        sstart;
      logic        send;
   } vertex_type;

   // One best-run item
   typedef struct packed {
      logic [11:0] min_x;
      logic [11:0] max_x;
      logic [11:0] width;
      logic [9:0]  points;
      logic        found;
   } arc_result_type;

   // -------------------------------------------------------------------------
   // Best-run predictor and result scoreboard
   // -------------------------------------------------------------------------
   class arc_scoreboard_type;
      carrt_pkg::xdir_type x_dir;
      carrt_pkg::ydir_type y_dir;
      logic [11:0]    lo_x, hi_x, prev_x, prev_y;
      logic [11:0]    best_lo, best_hi, best_w;
      logic [1:0]     turns;
      logic [9:0]     run_pts, best_pts;
      arc_result_type expected[$];
      int             mismatches;
      int             checked;

      function new();
         clear_run();
         best_lo = '0; best_hi = '0; best_w = '0; best_pts = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void clear_run();
         x_dir = carrt_pkg::XD_INIT;
         y_dir = carrt_pkg::YD_NONE;
         lo_x = '0; hi_x = '0; prev_x = '0; prev_y = '0;
         turns = '0;
         run_pts = '0;
      endfunction

      function void bump_points();
         if (run_pts < carrt_pkg::PTS_LIMIT) run_pts++;
      endfunction

      // Try to extend the current run; 0 means this vertex breaks it.
      // Direction and turn count may be touched even on a break.
      function bit grow(logic [11:0] x, logic [11:0] y);
         if (x > prev_x) begin
            if (x_dir == carrt_pkg::XD_LEFT) return 1'b0;
            x_dir = carrt_pkg::XD_RIGHT;
         end else begin
            if (x_dir == carrt_pkg::XD_RIGHT) return 1'b0;
            x_dir = carrt_pkg::XD_LEFT;
         end
         if (y > prev_y) begin
            if (y_dir == carrt_pkg::YD_UP) return 1'b0;
            y_dir = carrt_pkg::YD_DOWN;
         end else begin
            if (y_dir == carrt_pkg::YD_DOWN) begin
               if (turns < carrt_pkg::UPC_MAX) turns++;
               if (turns > carrt_pkg::UPC_LIMIT) return 1'b0;
            end
            y_dir = carrt_pkg::YD_UP;
         end
         if (x < lo_x) lo_x = x;
         else if (x > hi_x) hi_x = x;
         prev_x = x;
         prev_y = y;
         return 1'b1;
      endfunction

      function void add_vertex(logic [11:0] x, logic [11:0] y);
         logic [11:0] span;
         bump_points();
         if (x_dir == carrt_pkg::XD_INIT) begin
            x_dir = carrt_pkg::XD_NONE;
            lo_x = x; hi_x = x; prev_x = x; prev_y = y;
            return;
         end
         // flat step: drop the run unscored, restart here
         if (x == prev_x || y == prev_y) begin
            run_pts = 10'd1;
            turns = '0;
            x_dir = carrt_pkg::XD_NONE;
            y_dir = carrt_pkg::YD_NONE;
            lo_x = x; hi_x = x; prev_x = x; prev_y = y;
            return;
         end
         if (grow(x, y)) return;
         // break: score (breaking vertex already counted), restart at previous
         span = hi_x - lo_x;
         turns = '0;
         x_dir = (prev_x < x) ? carrt_pkg::XD_RIGHT :
                 (prev_x > x) ? carrt_pkg::XD_LEFT : carrt_pkg::XD_NONE;
         y_dir = (prev_y < y) ? carrt_pkg::YD_DOWN :
                 (prev_y > y) ? carrt_pkg::YD_UP : carrt_pkg::YD_NONE;
         if (run_pts > best_pts || (run_pts == best_pts && span > best_w)) begin
            best_pts = run_pts;
            best_lo = lo_x;
            best_hi = hi_x;
            best_w = span;
         end
         run_pts = 10'd1;
         lo_x = prev_x;
         hi_x = prev_x;
         bump_points();
         void'(grow(x, y));
      endfunction

      // Called for every accepted vertex item
      function void note_vertex(vertex_type v);
         arc_result_type r;
         if (v.sstart) begin
            best_lo = '0; best_hi = '0; best_w = '0; best_pts = '0;
         end
         if (v.size >= carrt_pkg::MIN_CONTOUR) begin
            if (v.cstart) clear_run();
            add_vertex(v.x, v.y);
         end
         if (v.send) begin
            r.min_x = best_lo;
            r.max_x = best_hi;
            r.width = best_w;
            r.points = best_pts;
            r.found = (best_w != 0);
            expected.push_back(r);
         end
      endfunction

      function void compare_field(string name, int unsigned want_v, int unsigned got_v);
         if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
         end
      endfunction

      // Called for every accepted result item
      function void check_result(logic [carrt_pkg::RSP_DATA_BITS-1:0] data, logic user);
         arc_result_type want;
         if (expected.size() == 0) begin
            $error("result item with nothing expected: tdata %h tuser %b", data, user);
            mismatches++;
            return;
         end
         want = expected.pop_front();
         checked++;
         compare_field("best_min_x", 32'(want.min_x), 32'(data[11:0]));
         compare_field("best_max_x", 32'(want.max_x), 32'(data[23:12]));
         compare_field("best_width", 32'(want.width), 32'(data[35:24]));
         compare_field("best_points", 32'(want.points), 32'(data[45:36]));
         compare_field("found", 32'(want.found), 32'(user));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   // [11:0] x, [23:12] y, [33:24] size, [39:34] 0
   logic [carrt_pkg::REQ_DATA_BITS-1:0] req_tdata;
   // [0] contour_start, [1] search_start
   logic [carrt_pkg::REQ_USER_BITS-1:0] req_tuser;
   logic                                req_tlast;   // search_end
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   // [11:0] min x, [23:12] max x, [35:24] width, [45:36] points, [47:46] 0
   logic [carrt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                                rsp_tuser;   // found

   contour_arc_run_tracker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   arc_scoreboard_type arcs = new();

   vertex_type stim[$];       // vertices waiting to be sent
   int      live_items = 0;   // queued vertices whose contour size is 3 or more
   int      items_sent = 0;
   int      burst_left = 0;
   int      cycles = 0;
   logic    hold_off_req = 1'b0;   // main asks the receiver for a long stall

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Stimulus builders
   // -------------------------------------------------------------------------
   function automatic void add_item(int x, int y, bit cs, int size, bit ss, bit se);
      vertex_type v;
      v.x = x[11:0];
      v.y = y[11:0];
      v.cstart = cs;
      v.size = size[9:0];
      v.sstart = ss;
      v.send = se;
      stim.push_back(v);
      if (v.size >= carrt_pkg::MIN_CONTOUR) live_items++;
   endfunction

   // One search: one or more contours, each mostly a well-formed arc (x one way,
   // y rising then falling) with random flat steps, backtracks and extra
   // y turns mixed in; some contours are pure noise, some are too short.
   function automatic void queue_search(int n_contours, int max_len);
      int  len, size, px, py, x_sign, turn_at, step_x, step_y, y_sign;
      bit  noise, first, last;
      for (int c = 0; c < n_contours; c++) begin
         size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 1023);
         len = $urandom_range(2, max_len);
         px = $urandom_range(0, 4095);
         py = $urandom_range(0, 4095);
         x_sign = $urandom_range(0, 1) ? 1 : -1;
         turn_at = $urandom_range(1, len);
         noise = ($urandom_range(0, 3) == 0);
         for (int v = 0; v < len; v++) begin
            if (v > 0) begin
               if (noise) begin
                  px = $urandom_range(0, 4095);
                  py = $urandom_range(0, 4095);
               end else begin
                  step_x = $urandom_range(1, 200);
                  case ($urandom_range(0, 15))
                     0:       step_x = 0;          // flat in x
                     1, 2:    step_x = -step_x;    // backtrack
                     default: ;
                  endcase
                  px += x_sign * step_x;
                  step_y = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 200);
                  y_sign = (v < turn_at) ? 1 : -1;
                  if ($urandom_range(0, 11) == 0) y_sign = -y_sign;   // stray y turn
                  py += y_sign * step_y;
               end
            end
            first = (c == 0 && v == 0);
            last = (c == n_contours - 1 && v == len - 1);
            add_item(px, py, v == 0 && $urandom_range(0, 29) != 0, size,
                     first || $urandom_range(0, 59) == 0,
                     last || $urandom_range(0, 79) == 0);
         end
      end
   endfunction

   // -------------------------------------------------------------------------
   // Sender: plays the stimulus queue in bursts with random gaps
   // -------------------------------------------------------------------------
   task automatic drive_items();
      vertex_type v;
      int      gap;
      while (stim.size() != 0) begin
         v = stim.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {6'd0, v.size, v.y, v.x};
         req_tuser  <= {v.sstart, v.cstart};
         req_tlast  <= v.send;
         do @(posedge clock); while (!req_tready);
         arcs.note_vertex(v);
         items_sent++;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
               0, 1, 2, 3: gap = 0;
               8:          gap = $urandom_range(8, 30);
               default:    gap = $urandom_range(1, 3);
            endcase
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (arcs.expected.size() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: stall pattern switches between random modes; a long
   // hold-off on request lets the block fill up and stall its input
   // -------------------------------------------------------------------------
   initial begin
      int         mode;
      int         mode_left;
      logic [2:0] tick;
      mode = 0;
      mode_left = 0;
      tick = '0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 80);
            end else begin
               mode_left--;
            end
            case (mode)
               0:       rsp_tready <= 1'b1;                           // no stalls
               1:       rsp_tready <= 1'($urandom_range(0, 1));       // coin flip
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);    // mostly stalled
               default: rsp_tready <= tick[2];                        // fixed square wave
            endcase
         end
      end
   end

   // Result checking and run-time limit
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_tvalid && rsp_tready) arcs.check_result(rsp_tdata, rsp_tuser);
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycles, arcs.expected.size());
         $display("** contour_arc_run_tracker: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int mark;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      req_tlast  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coordinate extremes, x backtrack scored at full width,
      // y falling then rising again, a single allowed turn, flat steps in x
      // and y, short contours with a start flag, end of search on an ignored
      // vertex, search start and end on one item with no best run, and a
      // final contour run that is dropped unscored.
      add_item(0,    0,    1, 3,    1, 0);
      add_item(10,   20,   0, 3,    0, 0);
      add_item(4095, 4095, 0, 3,    0, 0);
      add_item(4000, 100,  0, 3,    0, 0);   // x backtrack: scores 4 points
      add_item(3000, 200,  0, 3,    0, 0);   // y rises after falling
      add_item(2000, 100,  0, 3,    0, 0);   // one turn, allowed
      add_item(1000, 300,  0, 3,    0, 0);
      add_item(1000, 500,  0, 1023, 0, 0);   // flat in x
      add_item(1500, 500,  0, 1023, 0, 0);   // flat in y
      add_item(1600, 600,  0, 1023, 0, 0);
      add_item(0,    0,    1, 2,    0, 0);   // short contour, start ignored
      add_item(4095, 0,    0, 1,    0, 0);
      add_item(5,    5,    0, 0,    0, 1);   // ignored vertex still reports
      add_item(100,  4095, 1, 5,    1, 1);   // clear and report at once
      add_item(200,  3000, 0, 5,    0, 0);
      add_item(300,  2000, 0, 5,    0, 0);
      add_item(250,  1000, 0, 5,    0, 0);   // backtrack in a fresh search
      add_item(4095, 0,    1, 5,    0, 0);   // new contour drops last run
      add_item(4094, 4095, 0, 5,    0, 0);
      add_item(0,    0,    0, 5,    0, 1);
      drive_items();
      wait_drained();

      // Random searches, first half
      mark = live_items;
      while (live_items - mark < 250) queue_search($urandom_range(1, 4), 14);
      drive_items();

      // Receiver holds off while short searches keep coming
      hold_off_req = 1'b1;
      repeat (10) queue_search(1, 3);
      drive_items();
      wait_drained();   // sender pauses until every result is back

      // One long monotone run that saturates the point count, then a break
      for (int i = 0; i < 1030; i++) add_item(i, i, i == 0, 1023, i == 0, 0);
      add_item(1000, 2000, 0, 1023, 0, 0);
      add_item(900, 2100, 0, 1023, 0, 1);
      drive_items();

      // Random searches, second half
      mark = live_items;
      while (live_items - mark < 250) queue_search($urandom_range(1, 4), 14);
      drive_items();

      wait_drained();
      repeat (10) @(posedge clock);

      $display("Sent %0d vertex items (%0d in short contours), checked %0d best-run items",
               items_sent, items_sent - live_items, arcs.checked);
      $display("Covered flat steps, backtracks, y turns, saturation and a long output stall");
      if (arcs.mismatches == 0 && arcs.expected.size() == 0) begin
         $display("** contour_arc_run_tracker: PASSED **");
      end else begin
         $display("** contour_arc_run_tracker: FAILED **");
      end
      $finish;
   end

endmodule
